[rtl/rf_fingerprint_match_ranker_core_defines.svh]
// Assertion macros for the fingerprint match ranker.
`ifndef RF_FINGERPRINT_MATCH_RANKER_CORE_DEFINES_SVH
`define RF_FINGERPRINT_MATCH_RANKER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RFM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RFM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define RFM_ASSERT(label, clk, rst_n, prop, msg)
`define RFM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/rfm_pkg.sv]
package rfm_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned PatternBits  = 64;
  localparam int unsigned MaxOut       = 16;

  localparam logic KindQuery = 1'b0;
  localparam logic KindWrite = 1'b1;

  localparam logic [1:0] TypeNone    = 2'd0;
  localparam logic [1:0] TypePattern = 2'd1;
  localparam logic [1:0] TypePartial = 2'd2;
  localparam logic [1:0] TypeExact   = 2'd3;

  localparam logic [13:0] PassLevel    = 14'd3000;
  localparam logic [13:0] PartialLevel = 14'd5000;
  localparam logic [13:0] ExactLevel   = 14'd7000;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StScore,
    StDiv,
    StInsert,
    StEmit
  } state_e;

  function automatic logic [9:0] freq_score(input logic [19:0] d);
    if (d < 20'd10) return 10'd1000;
    else if (d < 20'd100) return 10'd900;
    else if (d < 20'd500) return 10'd700;
    else if (d < 20'd1000) return 10'd500;
    else return 10'd0;
  endfunction

endpackage

[rtl/rf_fingerprint_match_ranker_core.sv]
// Fingerprint match ranker.
// Input channel (valid/ready): kind 1 writes or removes one table slot,
// kind 0 queries the whole table. Output channel (valid/ready) carries
// the results of a query, best confidence first, the final one with last.
// A write gives no result, and the input is ready again in the next cycle.
// A query walks the slots in turn: an invalid slot is skipped; a valid
// slot with an empty pattern or a rolling code passes through memory read,
// scoring and insertion into the sorted list; any other valid slot also
// passes through the divider between scoring and insertion, as the
// equal-bit count is divided by the shorter length with a restoring
// divider of ten steps. After the last slot the walk closes and the
// results are offered; one result leaves per accepted output handshake.
// A query with no passing slot gives one result with match_found low.
// Reset clears the valid bits and the control state; the table memory
// keeps its contents and needs no clearing pass. While the receiver
// stalls, the current result holds and no new item is taken until the
// last result of the query has been accepted.
`include "rf_fingerprint_match_ranker_core_defines.svh"

module rf_fingerprint_match_ranker_core #(
  parameter int unsigned TABLE_ENTRIES = rfm_pkg::TableEntries,
  parameter int unsigned PATTERN_BITS  = rfm_pkg::PatternBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [3:0]  entry_index_i,
  input  logic [19:0] frequency_khz_i,
  input  logic [63:0] pattern_bits_i,
  input  logic [6:0]  pattern_length_i,
  input  logic        is_rolling_i,
  input  logic [3:0]  modulation_code_i,
  input  logic        entry_valid_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  match_index_o,
  output logic [13:0] confidence_o,
  output logic [1:0]  match_type_o,
  output logic        match_found_o,
  output logic        last_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned LenW = $clog2(PATTERN_BITS + 1);
  localparam int unsigned ListN = (TABLE_ENTRIES < rfm_pkg::MaxOut) ?
                                  TABLE_ENTRIES : rfm_pkg::MaxOut;
  localparam int unsigned ListW = $clog2(ListN + 1);
  localparam int unsigned LIdxW = (ListN > 1) ? $clog2(ListN) : 1;

  typedef struct packed {
    logic [19:0]             freq;
    logic [PATTERN_BITS-1:0] pat;
    logic [LenW-1:0]         len;
    logic                    roll;
    logic [3:0]              modc;
  } entry_t;

  entry_t                  mem_q [TABLE_ENTRIES];
  entry_t                  rd_q;
  logic [TABLE_ENTRIES-1:0] valid_q;

  rfm_pkg::state_e state_q, state_d;
  entry_t           qry_q;
  logic [CntW-1:0]  slot_q, slot_d;
  logic [13:0]      base_q, base_d;
  logic [9:0]       pscore_q, pscore_d;
  logic [LenW-1:0]  den_q, den_d;
  logic [3:0]       dstep_q, dstep_d;
  logic [13:0]      lconf_q [ListN];
  logic [IdxW-1:0]  lslot_q [ListN];
  logic [ListW-1:0] cnt_q, cnt_d;
  logic [ListW-1:0] ecnt_q, ecnt_d;

  logic             acc_in;
  logic [LenW-1:0]  len_in_sat;
  entry_t           wr_ent;
  logic [IdxW-1:0]  slot_idx;

  assign acc_in   = in_valid_i && in_ready_o;
  assign slot_idx = slot_q[IdxW-1:0];
  assign len_in_sat = (pattern_length_i > 7'(PATTERN_BITS)) ? LenW'(PATTERN_BITS)
                                                            : LenW'(pattern_length_i);
  assign wr_ent = '{freq: frequency_khz_i, pat: pattern_bits_i[PATTERN_BITS-1:0],
                    len: len_in_sat, roll: is_rolling_i, modc: modulation_code_i};

  always_ff @(posedge clk_i) begin
    if (acc_in && kind_i == rfm_pkg::KindWrite && entry_valid_i &&
        {28'd0, entry_index_i} < 32'(TABLE_ENTRIES)) begin
      mem_q[IdxW'(entry_index_i)] <= wr_ent;
    end
    rd_q <= mem_q[slot_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (acc_in && kind_i == rfm_pkg::KindWrite &&
                 {28'd0, entry_index_i} < 32'(TABLE_ENTRIES)) begin
      valid_q[IdxW'(entry_index_i)] <= entry_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) qry_q <= wr_ent;
  end

  // Scoring of the slot just read.
  logic [19:0]             fdist;
  logic [PATTERN_BITS-1:0] eqmask;
  logic [LenW-1:0]         nmin;
  logic [LenW-1:0]         eqcnt;
  logic [9:0]              fsc;
  logic [9:0]              msc;

  always_comb begin
    fdist = (qry_q.freq > rd_q.freq) ? qry_q.freq - rd_q.freq : rd_q.freq - qry_q.freq;
    fsc  = rfm_pkg::freq_score(fdist);
    msc  = (qry_q.modc == 4'd0 || rd_q.modc == 4'd0 || qry_q.modc == rd_q.modc) ?
           10'd1000 : 10'd500;
    nmin = (qry_q.len < rd_q.len) ? qry_q.len : rd_q.len;
    for (int b = 0; b < PATTERN_BITS; b++) begin
      eqmask[b] = (b < int'(nmin)) && (qry_q.pat[b] == rd_q.pat[b]);
    end
    eqcnt = LenW'($countones(eqmask));
  end

  // Insertion into the sorted list.
  logic [13:0]      conf_new;
  logic [ListW-1:0] pos;

  always_comb begin
    conf_new = base_q + 14'(5 * pscore_q);
    pos = cnt_q;
    for (int k = 0; k < ListN; k++) begin
      if (k < int'(cnt_q) && lconf_q[k] < conf_new && pos == cnt_q) pos = ListW'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rfm_pkg::StInsert && conf_new > rfm_pkg::PassLevel &&
        int'(pos) < ListN) begin
      for (int k = 1; k < ListN; k++) begin
        if (k > int'(pos)) begin
          lconf_q[k] <= lconf_q[k-1];
          lslot_q[k] <= lslot_q[k-1];
        end
      end
      lconf_q[pos[LIdxW-1:0]] <= conf_new;
      lslot_q[pos[LIdxW-1:0]] <= slot_idx;
    end
  end

  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    base_d   = base_q;
    pscore_d = pscore_q;
    den_d    = den_q;
    dstep_d  = dstep_q;
    cnt_d    = cnt_q;
    ecnt_d   = ecnt_q;
    in_ready_o = 1'b0;
    case (state_q)
      rfm_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i && kind_i == rfm_pkg::KindQuery) begin
          state_d = rfm_pkg::StRead;
          slot_d  = '0;
          cnt_d   = '0;
        end
      end
      rfm_pkg::StRead: begin
        if (slot_q == CntW'(TABLE_ENTRIES)) begin
          state_d = rfm_pkg::StEmit;
          ecnt_d  = '0;
        end else if (valid_q[slot_idx]) begin
          state_d = rfm_pkg::StScore;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      rfm_pkg::StScore: begin
        base_d   = 14'(4 * fsc) + 14'(msc);
        pscore_d = 10'd0;
        if (qry_q.len == '0 || rd_q.len == '0) begin
          state_d = rfm_pkg::StInsert;
        end else if (qry_q.roll || rd_q.roll) begin
          pscore_d = 10'd500;
          state_d  = rfm_pkg::StInsert;
        end else begin
          den_d   = nmin;
          dstep_d = '0;
          state_d = rfm_pkg::StDiv;
        end
      end
      rfm_pkg::StDiv: begin
        dstep_d = dstep_q + 1'b1;
        if (dstep_q == 4'd9) state_d = rfm_pkg::StInsert;
      end
      rfm_pkg::StInsert: begin
        if (conf_new > rfm_pkg::PassLevel && cnt_q < ListW'(ListN)) cnt_d = cnt_q + 1'b1;
        slot_d  = slot_q + 1'b1;
        state_d = rfm_pkg::StRead;
      end
      rfm_pkg::StEmit: begin
        if (out_ready_i) begin
          ecnt_d = ecnt_q + 1'b1;
          if (cnt_q == '0 || ecnt_q == cnt_q - 1'b1) state_d = rfm_pkg::StIdle;
        end
      end
      default: state_d = rfm_pkg::StIdle;
    endcase
  end

  // Restoring divider: dividend held in 17 bits, ten quotient bits.
  logic [16:0] dv_acc_q, dv_acc_d;

  always_comb begin
    dv_acc_d = dv_acc_q;
    if (state_q == rfm_pkg::StScore) begin
      dv_acc_d = 17'(eqcnt) * 17'd1000;
    end
  end

  // Long division over ten steps on a running partial remainder.
  logic [10:0] pr_q, pr_d;
  logic [10:0] pr_sh;

  always_comb begin
    pr_sh = {pr_q[9:0], dv_acc_q[4'd9 - dstep_q]};
    pr_d  = pr_q;
    if (state_q == rfm_pkg::StScore) begin
      pr_d = 11'(eqcnt * 1000 >> 10);
    end else if (state_q == rfm_pkg::StDiv) begin
      pr_d = (pr_sh >= 11'(den_q)) ? pr_sh - 11'(den_q) : pr_sh;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_acc_q <= dv_acc_d;
    pr_q     <= pr_d;
    if (state_q == rfm_pkg::StDiv) begin
      pscore_q <= {pscore_q[8:0], (pr_sh >= 11'(den_q))};
    end else begin
      pscore_q <= pscore_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfm_pkg::StIdle;
      slot_q  <= '0;
      cnt_q   <= '0;
      ecnt_q  <= '0;
      dstep_q <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      cnt_q   <= cnt_d;
      ecnt_q  <= ecnt_d;
      dstep_q <= dstep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    den_q  <= den_d;
  end

  logic [13:0] oc;
  assign oc            = lconf_q[ecnt_q[LIdxW-1:0]];
  assign out_valid_o   = (state_q == rfm_pkg::StEmit);
  assign match_found_o = (cnt_q != '0);
  assign match_index_o = match_found_o ? 4'(lslot_q[ecnt_q[LIdxW-1:0]]) : 4'd0;
  assign confidence_o  = match_found_o ? oc : 14'd0;
  assign match_type_o  = !match_found_o ? rfm_pkg::TypeNone :
                         (oc > rfm_pkg::ExactLevel) ? rfm_pkg::TypeExact :
                         (oc > rfm_pkg::PartialLevel) ? rfm_pkg::TypePartial :
                         rfm_pkg::TypePattern;
  assign last_o        = (cnt_q == '0) || (ecnt_q == cnt_q - 1'b1);

  `RFM_ASSERT_IMPL(a_no_take_busy, clk_i, rst_ni, state_q != rfm_pkg::StIdle, !in_ready_o,
                   "input taken while busy")
  `RFM_ASSERT_IMPL(a_out_in_excl, clk_i, rst_ni, out_valid_o, !in_ready_o,
                   "result and input overlap")
  `RFM_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= ListW'(ListN),
                   "list overflow")
  `RFM_ASSERT_IMPL(a_emit_bound, clk_i, rst_ni, out_valid_o,
                   ecnt_q < cnt_q || cnt_q == '0, "emit past list")

endmodule
